// ===== src/clt_pkg.sv =====
// clt_pkg: shared types and constants for the command line tokenizer.
// Holds character codes, record layout and queue sizing; no dependencies.
package clt_pkg;

  localparam int MAX_LINE_BYTES = 4096;

  localparam int START_W = 12;
  localparam int LEN_W   = 13;
  localparam int LTR_W   = 5;

  // Byte position must hold MAX_LINE_BYTES itself and feed the length field.
  localparam int POS_RAW_W = $clog2(MAX_LINE_BYTES + 1);
  localparam int POS_W     = (POS_RAW_W > LEN_W) ? POS_RAW_W : LEN_W;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_Z     = 8'h7A;

  typedef enum logic [1:0] {
    KIND_CMD    = 2'd0,
    KIND_PARAM  = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_MALFORMED = 2'd1,
    STATUS_TOO_LONG  = 2'd2
  } status_t;

  typedef struct packed {
    kind_t              kind;
    logic [LTR_W-1:0]   letter;
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   length;
    status_t            status;
    logic               final_rec;
  } rec_t;

  // Up to two records per input word; second is valid only with the first.
  typedef struct packed {
    logic v0;
    rec_t r0;
    logic v1;
    rec_t r1;
  } rec_pair_t;

endpackage

// ===== src/command_line_tokenizer.sv =====
// command_line_tokenizer: top level; input word register, parser, result queue.
// Instantiates clt_parse and clt_fifo; uses clt_pkg.
// An accepted word waits in the input word register until the result queue
// has room for a record pair; it is then parsed and its records are written
// into the queue that drives the output. Throughput: one word per cycle while
// the 4-entry queue has room for a pair; a word's second record drains after
// its first. rst (synchronous) empties the queue and returns the parser to line start.
module command_line_tokenizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  line_byte,
  input  logic        end_of_line,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  record_kind,
  output logic [4:0]  option_letter,
  output logic [11:0] token_start,
  output logic [12:0] token_length,
  output logic [1:0]  line_status,
  output logic        final_record
);

  logic               in_full;
  logic [7:0]         in_byte;
  logic               in_last;
  logic               room;
  logic               fire;
  clt_pkg::rec_pair_t recs, push;
  clt_pkg::rec_t      head;

  assign fire     = in_full && room;
  assign in_ready = !in_full || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte <= line_byte;
      in_last <= end_of_line;
    end
  end

  clt_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .in_byte (in_byte),
    .in_last (in_last),
    .recs    (recs)
  );

  always_comb begin
    push    = recs;
    push.v0 = recs.v0 && fire;
    push.v1 = recs.v1 && fire;
  end

  clt_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (out_valid && out_ready),
    .head      (head),
    .not_empty (out_valid),
    .room      (room)
  );

  assign record_kind   = head.kind;
  assign option_letter = head.letter;
  assign token_start   = head.start;
  assign token_length  = head.length;
  assign line_status   = head.status;
  assign final_record  = head.final_rec;

  a_final_is_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && final_record |-> record_kind == clt_pkg::KIND_STATUS)
    else $error("final record is not a status record");

  a_token_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && record_kind != clt_pkg::KIND_STATUS |->
      line_status == clt_pkg::STATUS_OK && !final_record)
    else $error("token record carries status bits");

  a_word_held: assert property (@(posedge clk) disable iff (rst)
    in_full && !room |=> in_full && $stable(in_byte) && $stable(in_last))
    else $error("stalled input word lost");

endmodule

// ===== src/clt_parse.sv =====
// clt_parse: per-byte tokenizer state and record generation.
// Handles one word per fire; uses clt_pkg.
module clt_parse (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  output clt_pkg::rec_pair_t recs
);

  typedef enum logic [2:0] {
    PH_CMD    = 3'd0,
    PH_SKIP   = 3'd1,
    PH_LETTER = 3'd2,
    PH_VALUE  = 3'd3,
    PH_BAD    = 3'd4,
    PH_LONG   = 3'd5
  } phase_t;

  typedef struct packed {
    phase_t                         phase;
    logic [clt_pkg::LTR_W-1:0]      letter;
    logic [clt_pkg::POS_W-1:0]      start;
    logic                           emit;
    logic                           is_param;
  } step_t;

  function automatic step_t feed_byte(input phase_t ph, input logic [7:0] c,
                                      input logic [clt_pkg::POS_W-1:0] pos,
                                      input logic [clt_pkg::LTR_W-1:0] ltr,
                                      input logic [clt_pkg::POS_W-1:0] st);
    step_t      s;
    logic [7:0] diff;
    s.phase    = ph;
    s.letter   = ltr;
    s.start    = st;
    s.emit     = 1'b0;
    s.is_param = 1'b0;
    diff       = c - clt_pkg::CH_A;
    unique case (ph)
      PH_CMD: begin
        if (c == clt_pkg::CH_SPACE) begin
          s.emit  = 1'b1;
          s.phase = PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (c != clt_pkg::CH_SPACE) begin
          if (c >= clt_pkg::CH_A && c <= clt_pkg::CH_Z) begin
            s.letter = diff[clt_pkg::LTR_W-1:0];
            s.phase  = PH_LETTER;
          end else begin
            s.phase = PH_BAD;
          end
        end
      end
      PH_LETTER: begin
        if (c == clt_pkg::CH_EQ) begin
          s.start = pos + clt_pkg::POS_W'(1);
          s.phase = PH_VALUE;
        end else begin
          s.phase = PH_BAD;
        end
      end
      PH_VALUE: begin
        if (c == clt_pkg::CH_SPACE) begin
          s.emit     = 1'b1;
          s.is_param = 1'b1;
          s.phase    = PH_SKIP;
        end
      end
      default: s.phase = PH_BAD;
    endcase
    return s;
  endfunction

  phase_t                    phase, phase_next;
  logic                      held, held_next;
  logic [clt_pkg::POS_W-1:0] pos, pos_next;
  logic [clt_pkg::POS_W-1:0] start, start_next;
  logic [clt_pkg::LTR_W-1:0] letter, letter_next;

  logic [clt_pkg::POS_W:0]   fill;
  logic                      long_trip;
  phase_t                    ph0;
  logic                      feed_held, feed_b;
  step_t                     s1, s2;
  logic [clt_pkg::POS_W-1:0] pos1, pos2, len_a, len_b;
  logic                      rec_a, rec_b;
  clt_pkg::rec_t             ra, rb, rc;

  always_comb begin
    fill      = {1'b0, pos} + {{clt_pkg::POS_W{1'b0}}, held};
    long_trip = (phase != PH_LONG) &&
                (fill >= (clt_pkg::POS_W + 1)'(clt_pkg::MAX_LINE_BYTES));
    ph0       = long_trip ? PH_LONG : phase;

    // A held CR is parsed unless the line closes on LF right after it.
    feed_held = held && !long_trip && (ph0 != PH_LONG) &&
                (!in_last || in_byte != clt_pkg::CH_LF);
    feed_b    = (ph0 != PH_LONG) && (in_byte != clt_pkg::CH_CR) &&
                (!in_last || in_byte != clt_pkg::CH_LF);

    s1 = '{phase: ph0, letter: letter, start: start, emit: 1'b0, is_param: 1'b0};
    if (feed_held) begin
      s1 = feed_byte(ph0, clt_pkg::CH_CR, pos, letter, start);
    end
    pos1 = pos + clt_pkg::POS_W'(feed_held);

    s2 = '{phase: s1.phase, letter: s1.letter, start: s1.start,
           emit: 1'b0, is_param: 1'b0};
    if (feed_b) begin
      s2 = feed_byte(s1.phase, in_byte, pos1, s1.letter, s1.start);
    end
    pos2 = pos1 + clt_pkg::POS_W'(feed_b);

    // Record from a space that closes a token
    rec_a = s2.emit;
    len_a = s2.is_param ? (pos1 - s1.start) : pos1;
    ra.kind      = s2.is_param ? clt_pkg::KIND_PARAM : clt_pkg::KIND_CMD;
    ra.letter    = s2.is_param ? s1.letter : '0;
    ra.start     = s2.is_param ? s1.start[clt_pkg::START_W-1:0] : '0;
    ra.length    = len_a[clt_pkg::LEN_W-1:0];
    ra.status    = clt_pkg::STATUS_OK;
    ra.final_rec = 1'b0;

    // Record for a token still open at line end
    rec_b = in_last && (s2.phase == PH_CMD || s2.phase == PH_VALUE);
    len_b = (s2.phase == PH_VALUE) ? (pos2 - s2.start) : pos2;
    rb.kind      = (s2.phase == PH_VALUE) ? clt_pkg::KIND_PARAM : clt_pkg::KIND_CMD;
    rb.letter    = (s2.phase == PH_VALUE) ? s2.letter : '0;
    rb.start     = (s2.phase == PH_VALUE) ? s2.start[clt_pkg::START_W-1:0] : '0;
    rb.length    = len_b[clt_pkg::LEN_W-1:0];
    rb.status    = clt_pkg::STATUS_OK;
    rb.final_rec = 1'b0;

    rc.kind      = clt_pkg::KIND_STATUS;
    rc.letter    = '0;
    rc.start     = '0;
    rc.length    = '0;
    rc.final_rec = 1'b1;
    if (s2.phase == PH_LONG) begin
      rc.status = clt_pkg::STATUS_TOO_LONG;
    end else if (rec_b) begin
      rc.status = clt_pkg::STATUS_OK;
    end else begin
      rc.status = clt_pkg::STATUS_MALFORMED;
    end

    recs.v0 = rec_a || rec_b || in_last;
    recs.r0 = rec_a ? ra : (rec_b ? rb : rc);
    recs.v1 = (rec_a || rec_b) && in_last;
    recs.r1 = rc;

    if (in_last) begin
      phase_next  = PH_CMD;
      held_next   = 1'b0;
      pos_next    = '0;
      start_next  = '0;
      letter_next = '0;
    end else begin
      phase_next  = s2.phase;
      held_next   = (ph0 != PH_LONG) && (in_byte == clt_pkg::CH_CR);
      pos_next    = pos2;
      start_next  = s2.start;
      letter_next = s2.letter;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_CMD;
      held   <= 1'b0;
      pos    <= '0;
      start  <= '0;
      letter <= '0;
    end else if (fire) begin
      phase  <= phase_next;
      held   <= held_next;
      pos    <= pos_next;
      start  <= start_next;
      letter <= letter_next;
    end
  end

endmodule

// ===== src/clt_fifo.sv =====
// clt_fifo: small result queue taking up to two records a cycle, one out.
// Uses clt_pkg for record type and depth.
module clt_fifo (
  input  logic               clk,
  input  logic               rst,
  input  clt_pkg::rec_pair_t push,
  input  logic               pop,
  output clt_pkg::rec_t      head,
  output logic               not_empty,
  output logic               room
);

  clt_pkg::rec_t             mem [clt_pkg::FIFO_DEPTH];
  logic [clt_pkg::PTR_W-1:0] rd_ptr, wr_ptr;
  logic [clt_pkg::CNT_W-1:0] count, count_next;
  logic [clt_pkg::PTR_W-1:0] wr_ptr1;
  logic [1:0]                push_n;

  always_comb begin
    wr_ptr1    = wr_ptr + clt_pkg::PTR_W'(1);
    push_n     = {1'b0, push.v0} + {1'b0, push.v1};
    count_next = count + clt_pkg::CNT_W'(push_n) - clt_pkg::CNT_W'(pop);
  end

  assign head      = mem[rd_ptr];
  assign not_empty = (count != '0);
  // Room for a full pair, judged on the registered count
  assign room      = (count <= clt_pkg::CNT_W'(clt_pkg::FIFO_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.v0) mem[wr_ptr] <= push.r0;
    if (push.v1) mem[wr_ptr1] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + clt_pkg::PTR_W'(push_n);
      if (pop) rd_ptr <= rd_ptr + clt_pkg::PTR_W'(1);
      count <= count_next;
    end
  end

endmodule

// ===== bench/clt_checker.sv =====
`timescale 1ns / 100ps
// clt_checker: watches both channels of the command line tokenizer, predicts
// the records each accepted word causes and compares them in order.
// Depends on clt_pkg for the record types and character codes.
module clt_checker
  import clt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  line_byte,
  input  logic        end_of_line,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  record_kind,
  input  logic [4:0]  option_letter,
  input  logic [11:0] token_start,
  input  logic [12:0] token_length,
  input  logic [1:0]  line_status,
  input  logic        final_record,
  output int          errors,
  output int          pending,
  output int          words,
  output int          records,
  output int          lines_ok,
  output int          lines_malformed,
  output int          lines_too_long
);

  typedef enum logic [2:0] {
    SCAN_CMD, SCAN_GAP, SCAN_KEY, SCAN_VALUE, SCAN_BAD, SCAN_LONG
  } scan_t;

  // Parser state of the predictor
  scan_t       scan       = SCAN_CMD;
  logic [7:0]  cr_byte    = 8'h00;
  logic        cr_pending = 1'b0;
  int unsigned pos        = 0;
  int unsigned val_start  = 0;
  int unsigned key        = 0;

  rec_t want_q[$];
  rec_t oldest;

  int mism = 0, n_words = 0, n_recs = 0, n_ok = 0, n_bad = 0, n_long = 0;

  function automatic void push_rec(kind_t k, int unsigned letter, int unsigned start,
                                   int unsigned len, status_t st);
    rec_t r;
    r.kind      = k;
    r.letter    = LTR_W'(letter);
    r.start     = START_W'(start);
    r.length    = LEN_W'(len);
    r.status    = st;
    r.final_rec = (k == KIND_STATUS);
    want_q.push_back(r);
  endfunction

  function automatic void restart();
    scan       = SCAN_CMD;
    cr_byte    = 8'h00;
    cr_pending = 1'b0;
    pos        = 0;
    val_start  = 0;
    key        = 0;
  endfunction

  function automatic void scan_char(logic [7:0] c);
    case (scan)
      SCAN_CMD: begin
        if (c == CH_SPACE) begin
          push_rec(KIND_CMD, 0, 0, pos, STATUS_OK);
          scan = SCAN_GAP;
        end
      end
      SCAN_GAP: begin
        if (c != CH_SPACE) begin
          if (c >= CH_A && c <= CH_Z) begin
            key  = c - CH_A;
            scan = SCAN_KEY;
          end else begin
            scan = SCAN_BAD;
          end
        end
      end
      SCAN_KEY: begin
        if (c == CH_EQ) begin
          val_start = pos + 1;
          scan      = SCAN_VALUE;
        end else begin
          scan = SCAN_BAD;
        end
      end
      SCAN_VALUE: begin
        if (c == CH_SPACE) begin
          push_rec(KIND_PARAM, key, val_start, pos - val_start, STATUS_OK);
          scan = SCAN_GAP;
        end
      end
      default: scan = SCAN_BAD;
    endcase
    pos++;
  endfunction

  function automatic void close_line();
    status_t st;
    case (scan)
      SCAN_CMD: begin
        push_rec(KIND_CMD, 0, 0, pos, STATUS_OK);
        st = STATUS_OK;
      end
      SCAN_VALUE: begin
        push_rec(KIND_PARAM, key, val_start, pos - val_start, STATUS_OK);
        st = STATUS_OK;
      end
      SCAN_LONG: st = STATUS_TOO_LONG;
      default:   st = STATUS_MALFORMED;
    endcase
    push_rec(KIND_STATUS, 0, 0, 0, st);
    case (st)
      STATUS_OK:        n_ok++;
      STATUS_MALFORMED: n_bad++;
      default:          n_long++;
    endcase
    restart();
  endfunction

  function automatic void predict_word(logic [7:0] b, logic last);
    // A word at raw offset MAX_LINE_BYTES or beyond spoils the line.
    if (scan != SCAN_LONG && pos + cr_pending + 1 > MAX_LINE_BYTES) begin
      scan       = SCAN_LONG;
      cr_pending = 1'b0;
    end
    if (scan == SCAN_LONG) begin
      if (last) close_line();
    end else if (!last) begin
      if (cr_pending) begin
        scan_char(cr_byte);
        cr_pending = 1'b0;
      end
      // hold a CR until we know whether it ends the line
      if (b == CH_CR) begin
        cr_byte    = b;
        cr_pending = 1'b1;
      end else begin
        scan_char(b);
      end
    end else begin
      // drop a final LF, then a final CR
      if (b != CH_LF) begin
        if (cr_pending) scan_char(cr_byte);
        if (b != CH_CR) scan_char(b);
      end
      close_line();
    end
  endfunction

  function automatic void check_field(string name, int exp, int act);
    if (exp != act) begin
      mism++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      restart();
      want_q.delete();
    end else begin
      if (in_valid && in_ready) begin
        predict_word(line_byte, end_of_line);
        n_words++;
      end
      if (out_valid && out_ready) begin
        n_recs++;
        if (want_q.size() == 0) begin
          mism++;
          $display("%0t: unexpected record, expected none, ", $time,
                   "actual kind %0d letter %0d start %0d ", record_kind, option_letter,
                   token_start,
                   "length %0d status %0d final %0d", token_length, line_status,
                   final_record);
        end else begin
          oldest = want_q.pop_front();
          check_field("record_kind", oldest.kind, record_kind);
          check_field("option_letter", oldest.letter, option_letter);
          check_field("token_start", oldest.start, token_start);
          check_field("token_length", oldest.length, token_length);
          check_field("line_status", oldest.status, line_status);
          check_field("final_record", oldest.final_rec, final_record);
        end
      end
    end
    errors          <= mism;
    pending         <= want_q.size();
    words           <= n_words;
    records         <= n_recs;
    lines_ok        <= n_ok;
    lines_malformed <= n_bad;
    lines_too_long  <= n_long;
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// tb: top of the command line tokenizer bench; sends lines a word at a time
// with random gaps and back-pressure and gives the verdict.
// Depends on clt_pkg, command_line_tokenizer and clt_checker.
module tb;
  import clt_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int RANDOM_WORDS = 1400;
  localparam int DRAIN_CYCLES = 10;

  logic        clk;
  logic        rst         = 1'b1;
  logic        in_valid    = 1'b0;
  logic        in_ready;
  logic [7:0]  line_byte   = 8'h00;
  logic        end_of_line = 1'b0;
  logic        out_valid;
  logic        out_ready   = 1'b0;
  logic [1:0]  record_kind;
  logic [4:0]  option_letter;
  logic [11:0] token_start;
  logic [12:0] token_length;
  logic [1:0]  line_status;
  logic        final_record;

  int errors, pending, words, records, lines_ok, lines_malformed, lines_too_long;

  int send_idle  = 13;
  int recv_idle  = 66;
  int words_sent = 0;
  int quiet      = 0;

  logic [7:0] text_q[$];

  command_line_tokenizer dut (
    .clk, .rst, .in_valid, .in_ready, .line_byte, .end_of_line,
    .out_valid, .out_ready, .record_kind, .option_letter, .token_start,
    .token_length, .line_status, .final_record
  );

  clt_checker u_checker (
    .clk, .rst, .in_valid, .in_ready, .line_byte, .end_of_line,
    .out_valid, .out_ready, .record_kind, .option_letter, .token_start,
    .token_length, .line_status, .final_record,
    .errors, .pending, .words, .records, .lines_ok, .lines_malformed,
    .lines_too_long
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic put_word(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    line_byte   <= b;
    end_of_line <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_line();
    foreach (text_q[i]) put_word(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  function automatic logic [7:0] token_char();
    logic [7:0] c;
    if ($urandom_range(9) == 0) begin
      c = 8'($urandom_range(0, 255));
      if (c == CH_SPACE) c = CH_CR;
    end else begin
      c = 8'($urandom_range(8'h21, 8'h7E));
    end
    return c;
  endfunction

  // Mostly well-formed lines with random content; some broken, some noise.
  task automatic build_line();
    int shape;
    shape = $urandom_range(99);
    if (shape >= 88) begin
      repeat ($urandom_range(1, 10)) text_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 6)) text_q.push_back(token_char());
      repeat ($urandom_range(0, 3)) begin
        repeat ($urandom_range(1, 2)) text_q.push_back(CH_SPACE);
        text_q.push_back(8'(CH_A + $urandom_range(0, 25)));
        text_q.push_back(CH_EQ);
        repeat ($urandom_range(0, 5)) text_q.push_back(token_char());
      end
      if (shape >= 75) begin
        case ($urandom_range(0, 4))
          0: repeat ($urandom_range(1, 3)) text_q.push_back(CH_SPACE);
          1: begin
            text_q.push_back(CH_SPACE);
            text_q.push_back(8'(CH_A + $urandom_range(0, 25)));
          end
          2: begin
            if (text_q.size() > 0)
              text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
          end
          3: begin
            text_q.push_back(CH_SPACE);
            text_q.push_back(8'($urandom_range(8'h30, 8'h5A)));
            text_q.push_back(CH_EQ);
          end
          default: begin
            text_q.push_back(CH_SPACE);
            text_q.push_back(8'(CH_A + $urandom_range(0, 25)));
            text_q.push_back(token_char());
          end
        endcase
      end
      case ($urandom_range(0, 3))
        1: text_q.push_back(CH_LF);
        2: begin
          text_q.push_back(CH_CR);
          text_q.push_back(CH_LF);
        end
        3: text_q.push_back(CH_CR);
        default: ;
      endcase
    end
    if (text_q.size() == 0) text_q.push_back(CH_LF);
  endtask

  initial begin
    int base;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // empty lines: lone LF, lone CR
    text_q.push_back(CH_LF);
    send_line();
    text_q.push_back(CH_CR);
    send_line();
    add_text("ls");
    send_line();
    add_text("get k=v x=12");
    text_q.push_back(CH_CR);
    text_q.push_back(CH_LF);
    send_line();
    add_text("put a=1 z=xyz");
    text_q.push_back(CH_LF);
    send_line();
    add_text("run a= b=");
    send_line();
    add_text("a=b");
    send_line();
    // CR inside the line is an ordinary character
    add_text("a");
    text_q.push_back(CH_CR);
    add_text("b c=");
    text_q.push_back(CH_CR);
    add_text("d");
    text_q.push_back(CH_CR);
    send_line();
    add_text("x");
    text_q.push_back(CH_CR);
    text_q.push_back(CH_LF);
    add_text("y z=1");
    send_line();
    add_text("cmd A=1");
    send_line();
    add_text("cmd ab=1");
    send_line();
    add_text("cmd k=1   ");
    send_line();
    add_text("cmd k");
    send_line();
    add_text("c `=1");
    send_line();
    add_text("c {=1");
    send_line();
    add_text("c z=9 a=0");
    send_line();
    add_text("  k=1");
    send_line();
    add_text("go k=1 ");
    text_q.push_back(CH_LF);
    send_line();
    add_text("cmd ");
    text_q.push_back(CH_CR);
    send_line();
    text_q.push_back(8'h00);
    text_q.push_back(8'hFF);
    text_q.push_back(CH_SPACE);
    text_q.push_back("m");
    text_q.push_back(CH_EQ);
    text_q.push_back(8'hFF);
    text_q.push_back(8'h00);
    send_line();

    base = words_sent;
    while (words_sent - base < RANDOM_WORDS) begin
      if (words_sent - base >= 2 * RANDOM_WORDS / 3) begin
        send_idle = 0;
        recv_idle <= 0;
      end else if (words_sent - base >= RANDOM_WORDS / 3) begin
        send_idle = 66;
        recv_idle <= 13;
      end
      build_line();
      send_line();
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d words in %0d lines, checked %0d records", words,
             lines_ok + lines_malformed + lines_too_long, records);
    $display("Line endings seen: %0d ok, %0d malformed, %0d too long",
             lines_ok, lines_malformed, lines_too_long);
    if (errors == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
